// File: src/dcsio_pkg.sv
// package: types, constants and sizes for the dual channel serial controller
package dcsio_pkg;

   localparam int TX_DEPTH    = 2;
   localparam int RX_DEPTH    = 4;
   localparam int STAGE_DEPTH = 8;

   localparam int TX_IW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
   localparam int RX_IW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
   localparam int ST_IW = (STAGE_DEPTH > 1) ? $clog2(STAGE_DEPTH) : 1;
   localparam int TX_CW = $clog2(TX_DEPTH + 1);
   localparam int RX_CW = $clog2(RX_DEPTH + 1);
   localparam int ST_CW = $clog2(STAGE_DEPTH + 1);

   typedef enum logic [2:0] {
      CMD_WRITE    = 3'd0,
      CMD_READ     = 3'd1,
      CMD_RX_BYTE  = 3'd2,
      CMD_RX_CLEAR = 3'd3,
      CMD_TX_TICK  = 3'd4,
      CMD_RX_TICK  = 3'd5,
      CMD_RETI     = 3'd6
   } cmd_type;

   // wr0 command field, bits 5:3
   localparam logic [2:0] WR0_CHAN_RESET = 3'b011;
   localparam logic [2:0] WR0_RX_INT_EN  = 3'b100;
   localparam logic [2:0] WR0_TX_INT_CLR = 3'b101;
   localparam logic [2:0] WR0_ERR_RESET  = 3'b110;

   localparam logic [2:0] PTR_RR0 = 3'd0;
   localparam logic [2:0] PTR_RR1 = 3'd1;
   localparam logic [2:0] PTR_RR2 = 3'd2;
   localparam logic [2:0] PTR_WR5 = 3'd5;

   localparam logic [2:0] ST_TX_EMPTY = 3'd2;
   localparam logic [2:0] ST_TX_BUF   = 3'd0;
   localparam logic [2:0] ST_RX_CHAR  = 3'd4;
   localparam logic [2:0] ST_RX_SPEC  = 3'd6;

   localparam logic [7:0] RR1_BASE  = 8'h8e;
   localparam logic [4:0] RIC_MAX   = 5'd31;

   typedef struct packed {
      logic [2:0] cmd;
      logic       channel;
      logic       reg_select;
      logic [7:0] data;
      logic       int_pending;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       rts_changed;
      logic       rts_level;
      logic       dtr_changed;
      logic       dtr_level;
      logic       irq_request;
      logic [7:0] irq_vector;
      logic       irq_cancel;
   } rsp_type;

   typedef struct packed {
      logic next_rx_int;
      logic rx_first;
      logic tx_int;
      logic rx_overrun;
      logic tx_underrun;
      logic tx_active;
      logic rx_active;
   } chan_flags_type;

   localparam chan_flags_type FLAGS_RESET = '{
      next_rx_int: 1'b0, rx_first: 1'b0, tx_int: 1'b0, rx_overrun: 1'b0,
      tx_underrun: 1'b1, tx_active: 1'b0, rx_active: 1'b0};

endpackage

// File: src/dual_channel_serial_io_controller_unit.sv
// top level: two channel serial controller with register file, fifos and interrupts
//
// usage: every item on req_ (bus write/read, rx byte, rx clear, tx tick,
// rx tick, reti) gives exactly one item on rsp_ holding read data, the sent
// byte, rts/dtr changes and interrupt request/cancel with its vector.
// items pass an input register and then one stage of logic that updates the
// channel state and loads the result register.
// throughput: 1 item per cycle; a new item is taken while the previous
// result sits in the result register, as long as rsp_stall is low.
// when rsp_stall is high the result holds, the input register fills and
// req_stall rises; nothing is dropped.
// reset (synchronous): write registers, pointers and fifos cleared,
// underflow flags set, vector 0, both stages empty.
module dual_channel_serial_io_controller_unit
   import dcsio_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   req_type        req_ff;
   logic           req_valid_ff, req_valid_in;
   rsp_type        rsp_ff, rsp_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           advance, proc;

   logic [7:0]     wr_ff [2][8];
   logic [7:0]     wr_in [2][8];
   logic [2:0]     ptr_ff [2];
   logic [2:0]     ptr_in [2];
   logic [7:0]     txb_ff [2][TX_DEPTH];
   logic [7:0]     txb_in [2][TX_DEPTH];
   logic [TX_IW-1:0] txh_ff [2];
   logic [TX_IW-1:0] txh_in [2];
   logic [TX_CW-1:0] txc_ff [2];
   logic [TX_CW-1:0] txc_in [2];
   logic [7:0]     rxb_ff [2][RX_DEPTH];
   logic [7:0]     rxb_in [2][RX_DEPTH];
   logic [RX_IW-1:0] rxh_ff [2];
   logic [RX_IW-1:0] rxh_in [2];
   logic [RX_CW-1:0] rxc_ff [2];
   logic [RX_CW-1:0] rxc_in [2];
   logic [7:0]     stb_ff [2][STAGE_DEPTH];
   logic [7:0]     stb_in [2][STAGE_DEPTH];
   logic [ST_IW-1:0] sth_ff [2];
   logic [ST_IW-1:0] sth_in [2];
   logic [ST_CW-1:0] stc_ff [2];
   logic [ST_CW-1:0] stc_in [2];
   chan_flags_type flags_ff [2];
   chan_flags_type flags_in [2];
   logic [4:0]     ric_ff [2];
   logic [4:0]     ric_in [2];
   logic [7:0]     vec_ff, vec_in;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign proc      = req_valid_ff && advance;
   assign req_stall = req_valid_ff && !advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign req_valid_in = (req_valid && !req_stall) ? 1'b1 : (proc ? 1'b0 : req_valid_ff);
   assign rsp_valid_in = proc ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   // status-modified vector from channel b wr1/wr2
   function automatic logic [7:0] make_vector(input logic [7:0] wr1b, input logic [7:0] wr2b,
                                              input logic ch, input logic [2:0] st);
      if (wr1b[2]) begin
         return {wr2b[7:4], ~ch, st};
      end
      return {wr2b[7:1], 1'b0};
   endfunction

   always_comb begin
      logic            c;
      logic [7:0]      d;
      logic [TX_CW:0]  tx_sum;
      logic [RX_CW:0]  rx_sum;
      logic [ST_CW:0]  st_sum;
      logic [7:0]      sbyte;
      logic            want;
      wr_in    = wr_ff;
      ptr_in   = ptr_ff;
      txb_in   = txb_ff;
      txh_in   = txh_ff;
      txc_in   = txc_ff;
      rxb_in   = rxb_ff;
      rxh_in   = rxh_ff;
      rxc_in   = rxc_ff;
      stb_in   = stb_ff;
      sth_in   = sth_ff;
      stc_in   = stc_ff;
      flags_in = flags_ff;
      ric_in   = ric_ff;
      vec_in   = vec_ff;
      rsp_in   = '0;
      c        = req_ff.channel;
      d        = req_ff.data;
      tx_sum   = '0;
      rx_sum   = '0;
      st_sum   = '0;
      sbyte    = '0;
      want     = 1'b0;
      if (proc) begin
         case (cmd_type'(req_ff.cmd))
            CMD_WRITE: begin
               if (!req_ff.reg_select) begin
                  if (txc_ff[c] < TX_CW'(TX_DEPTH)) begin
                     tx_sum = (TX_CW+1)'(txh_ff[c]) + (TX_CW+1)'(txc_ff[c]);
                     if (tx_sum >= (TX_CW+1)'(TX_DEPTH)) begin
                        tx_sum = tx_sum - (TX_CW+1)'(TX_DEPTH);
                     end
                     txb_in[c][tx_sum[TX_IW-1:0]] = d;
                     txc_in[c] = txc_ff[c] + 1'b1;
                  end
                  flags_in[c].tx_active = 1'b1;
                  flags_in[c].tx_int    = 1'b0;
               end else begin
                  if (ptr_ff[c] == PTR_RR0) begin
                     unique case (d[5:3])
                        WR0_CHAN_RESET: begin
                           for (int k = 0; k < 8; k++) begin
                              wr_in[c][k] = '0;
                           end
                           txh_in[c]   = '0;
                           txc_in[c]   = '0;
                           rxh_in[c]   = '0;
                           rxc_in[c]   = '0;
                           sth_in[c]   = '0;
                           stc_in[c]   = '0;
                           flags_in[c] = FLAGS_RESET;
                           ric_in[c]   = '0;
                        end
                        WR0_RX_INT_EN:  flags_in[c].next_rx_int = 1'b1;
                        WR0_TX_INT_CLR: flags_in[c].tx_int      = 1'b0;
                        WR0_ERR_RESET:  flags_in[c].rx_overrun  = 1'b0;
                        default: ;
                     endcase
                     if (d[7:6] == 2'b11) begin
                        flags_in[c].tx_underrun = 1'b0;
                     end
                  end else if (ptr_ff[c] == PTR_WR5) begin
                     if (wr_ff[c][5][1] != d[1]) begin
                        rsp_in.rts_changed = 1'b1;
                        rsp_in.rts_level   = ~d[1];
                     end
                     if (wr_ff[c][5][7] != d[7]) begin
                        rsp_in.dtr_changed = 1'b1;
                        rsp_in.dtr_level   = ~d[7];
                     end
                  end
                  wr_in[c][ptr_ff[c]] = d;
                  ptr_in[c] = (ptr_ff[c] == PTR_RR0) ? d[2:0] : PTR_RR0;
               end
            end
            CMD_READ: begin
               if (!req_ff.reg_select) begin
                  if (ric_ff[c] != '0) begin
                     ric_in[c] = ric_ff[c] - 1'b1;
                     rsp_in.irq_cancel = (ric_ff[c] == 5'd1);
                  end
                  if (rxc_ff[c] != '0) begin
                     rsp_in.read_data = rxb_ff[c][rxh_ff[c]];
                     rxh_in[c] = (rxh_ff[c] == RX_IW'(RX_DEPTH - 1)) ? '0 : rxh_ff[c] + 1'b1;
                     rxc_in[c] = rxc_ff[c] - 1'b1;
                  end
               end else begin
                  if (ptr_ff[c] == PTR_RR0) begin
                     rsp_in.read_data[0] = (rxc_ff[c] != '0);
                     rsp_in.read_data[1] = !c && req_ff.int_pending;
                     rsp_in.read_data[2] = (txc_ff[c] < TX_CW'(TX_DEPTH));
                     rsp_in.read_data[6] = flags_ff[c].tx_underrun;
                  end else if (ptr_ff[c] == PTR_RR1) begin
                     rsp_in.read_data    = RR1_BASE;
                     rsp_in.read_data[0] = (txc_ff[c] == '0);
                     rsp_in.read_data[5] = flags_ff[c].rx_overrun;
                  end else if (ptr_ff[c] == PTR_RR2) begin
                     rsp_in.read_data = c ? vec_ff : 8'h00;
                  end
                  ptr_in[c] = PTR_RR0;
               end
            end
            CMD_RX_BYTE: begin
               if (wr_ff[c][3][0]) begin
                  flags_in[c].rx_active = 1'b1;
                  if (stc_ff[c] == '0) begin
                     flags_in[c].rx_first = 1'b1;
                  end
                  if (stc_ff[c] < ST_CW'(STAGE_DEPTH)) begin
                     st_sum = (ST_CW+1)'(sth_ff[c]) + (ST_CW+1)'(stc_ff[c]);
                     if (st_sum >= (ST_CW+1)'(STAGE_DEPTH)) begin
                        st_sum = st_sum - (ST_CW+1)'(STAGE_DEPTH);
                     end
                     stb_in[c][st_sum[ST_IW-1:0]] = d;
                     stc_in[c] = stc_ff[c] + 1'b1;
                  end
               end
            end
            CMD_RX_CLEAR: begin
               if (d != '0) begin
                  flags_in[c].rx_active = 1'b0;
                  ric_in[c] = '0;
                  sth_in[c] = '0;
                  stc_in[c] = '0;
                  rxh_in[c] = '0;
                  rxc_in[c] = '0;
               end
            end
            CMD_TX_TICK: begin
               if (flags_ff[c].tx_active && wr_ff[c][5][3]) begin
                  rsp_in.tx_valid = 1'b1;
                  if (txc_ff[c] != '0) begin
                     rsp_in.tx_byte = txb_ff[c][txh_ff[c]];
                     txh_in[c] = (txh_ff[c] == TX_IW'(TX_DEPTH - 1)) ? '0 : txh_ff[c] + 1'b1;
                     txc_in[c] = txc_ff[c] - 1'b1;
                  end
                  // count after the take decides between empty and buffer-free
                  if (txc_ff[c] <= TX_CW'(1)) begin
                     if (wr_ff[c][1][0]) begin
                        vec_in = make_vector(wr_ff[1][1], wr_ff[1][2], c, ST_TX_EMPTY);
                        rsp_in.irq_request = 1'b1;
                        rsp_in.irq_vector  = vec_in;
                     end
                     flags_in[c].tx_underrun = 1'b1;
                     flags_in[c].tx_active   = 1'b0;
                  end else if (wr_ff[c][1][1]) begin
                     vec_in = make_vector(wr_ff[1][1], wr_ff[1][2], c, ST_TX_BUF);
                     rsp_in.irq_request = 1'b1;
                     rsp_in.irq_vector  = vec_in;
                     flags_in[c].tx_int = 1'b1;
                  end
               end
            end
            CMD_RX_TICK: begin
               if (flags_ff[c].rx_active) begin
                  if (rxc_ff[c] >= RX_CW'(RX_DEPTH)) begin
                     vec_in = make_vector(wr_ff[1][1], wr_ff[1][2], c, ST_RX_SPEC);
                     rsp_in.irq_request = 1'b1;
                     rsp_in.irq_vector  = vec_in;
                     flags_in[c].rx_overrun = 1'b1;
                     if (stc_ff[c] == '0) begin
                        flags_in[c].rx_active = 1'b0;
                     end
                  end else begin
                     // an empty staging fifo still moves a zero byte
                     if (stc_ff[c] != '0) begin
                        sbyte = stb_ff[c][sth_ff[c]];
                        sth_in[c] = (sth_ff[c] == ST_IW'(STAGE_DEPTH - 1)) ?
                                    '0 : sth_ff[c] + 1'b1;
                        stc_in[c] = stc_ff[c] - 1'b1;
                     end
                     rx_sum = (RX_CW+1)'(rxh_ff[c]) + (RX_CW+1)'(rxc_ff[c]);
                     if (rx_sum >= (RX_CW+1)'(RX_DEPTH)) begin
                        rx_sum = rx_sum - (RX_CW+1)'(RX_DEPTH);
                     end
                     rxb_in[c][rx_sum[RX_IW-1:0]] = sbyte;
                     rxc_in[c] = rxc_ff[c] + 1'b1;
                     want = (wr_ff[c][1][4:3] == 2'b01 &&
                             (flags_ff[c].rx_first || flags_ff[c].next_rx_int)) ||
                            wr_ff[c][1][4];
                     if (want) begin
                        vec_in = make_vector(wr_ff[1][1], wr_ff[1][2], c, ST_RX_CHAR);
                        rsp_in.irq_request = 1'b1;
                        rsp_in.irq_vector  = vec_in;
                        if (ric_ff[c] < RIC_MAX) begin
                           ric_in[c] = ric_ff[c] + 1'b1;
                        end
                     end
                     flags_in[c].rx_first    = 1'b0;
                     flags_in[c].next_rx_int = 1'b0;
                     if (stc_ff[c] <= ST_CW'(1)) begin
                        flags_in[c].rx_active = 1'b0;
                     end
                  end
               end
            end
            CMD_RETI: begin
               if (flags_ff[0].tx_int && wr_ff[0][1][1]) begin
                  vec_in = make_vector(wr_ff[1][1], wr_ff[1][2], 1'b0, ST_TX_BUF);
                  rsp_in.irq_request = 1'b1;
                  rsp_in.irq_vector  = vec_in;
               end else if (flags_ff[1].tx_int && wr_ff[1][1][1]) begin
                  vec_in = make_vector(wr_ff[1][1], wr_ff[1][2], 1'b1, ST_TX_BUF);
                  rsp_in.irq_request = 1'b1;
                  rsp_in.irq_vector  = vec_in;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 2; k++) begin
            for (int j = 0; j < 8; j++) begin
               wr_ff[k][j] <= '0;
            end
            ptr_ff[k]   <= '0;
            txh_ff[k]   <= '0;
            txc_ff[k]   <= '0;
            rxh_ff[k]   <= '0;
            rxc_ff[k]   <= '0;
            sth_ff[k]   <= '0;
            stc_ff[k]   <= '0;
            flags_ff[k] <= FLAGS_RESET;
            ric_ff[k]   <= '0;
         end
         vec_ff <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         wr_ff        <= wr_in;
         ptr_ff       <= ptr_in;
         txh_ff       <= txh_in;
         txc_ff       <= txc_in;
         rxh_ff       <= rxh_in;
         rxc_ff       <= rxc_in;
         sth_ff       <= sth_in;
         stc_ff       <= stc_in;
         flags_ff     <= flags_in;
         ric_ff       <= ric_in;
         vec_ff       <= vec_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_ff <= req_data;
      end
      if (proc) begin
         rsp_ff <= rsp_in;
      end
      txb_ff <= txb_in;
      rxb_ff <= rxb_in;
      stb_ff <= stb_in;
   end

endmodule

// File: src/dcsio_checker.sv
// checker: port-level properties of the serial controller, bound to the top level
module dcsio_port_props
   import dcsio_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // a held result stays shown and unchanged
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result item dropped or changed while stalled");

   assert property (@(posedge clock) reset |=> !rsp_valid && !req_stall)
      else $error("result item shown or input stalled after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.tx_valid |-> rsp_data.tx_byte == 8'h00)
      else $error("tx byte without tx valid");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.irq_request |-> rsp_data.irq_vector == 8'h00)
      else $error("vector without interrupt request");

   // only a tx tick sends, only a data read cancels
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.tx_valid |-> !rsp_data.irq_cancel && rsp_data.read_data == 8'h00)
      else $error("tx byte mixed with bus read result");

endmodule

bind dual_channel_serial_io_controller_unit dcsio_port_props u_dcsio_port_props (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
